// ----- sv/lcpq_pkg.sv -----
// ----------------------------------------------------------------------------
// LC presence qualifier package
// Shared widths, register indexes, reset values and item types.
// ----------------------------------------------------------------------------
package lcpq_pkg;

    localparam int LCPQ_CH_W      = 3;
    localparam int LCPQ_CNT_W     = 8;
    localparam int LCPQ_TRIG_W    = 6;
    localparam int LCPQ_REP_W     = 3;
    localparam int LCPQ_HOLD_W    = 8;
    localparam int LCPQ_USE_W     = 4;
    localparam int LCPQ_CFG_IDX_W = 2;
    localparam int LCPQ_CFG_DATA_W = 8;

    localparam int LCPQ_CHANNELS = 8;
    localparam int LCPQ_CH_SPAN  = 2 ** LCPQ_CH_W;

    localparam logic [LCPQ_CFG_IDX_W-1:0] REG_TRIGGER_LEVEL   = 2'd0;
    localparam logic [LCPQ_CFG_IDX_W-1:0] REG_REPEAT_NEEDED   = 2'd1;
    localparam logic [LCPQ_CFG_IDX_W-1:0] REG_HOLD_TIME       = 2'd2;
    localparam logic [LCPQ_CFG_IDX_W-1:0] REG_CHANNELS_IN_USE = 2'd3;

    localparam logic [LCPQ_TRIG_W-1:0] TRIGGER_LEVEL_RST   = 6'd37;
    localparam logic [LCPQ_REP_W-1:0]  REPEAT_NEEDED_RST   = 3'd5;
    localparam logic [LCPQ_HOLD_W-1:0] HOLD_TIME_RST       = 8'd180;
    localparam logic [LCPQ_USE_W-1:0]  CHANNELS_IN_USE_RST = 4'd0;

    typedef struct packed {
        logic [LCPQ_TRIG_W-1:0] trigger_level;
        logic [LCPQ_REP_W-1:0]  repeat_needed;
        logic [LCPQ_HOLD_W-1:0] hold_time;
        logic [LCPQ_USE_W-1:0]  channels_in_use;
    } cfg_t;

    typedef struct packed {
        logic [LCPQ_CH_W-1:0]  channel;
        logic [LCPQ_CNT_W-1:0] pulse_count;
    } in_item_t;

    typedef struct packed {
        logic                   accepted;
        logic [LCPQ_HOLD_W-1:0] hold_value;
        logic                   active;
        logic [LCPQ_REP_W-1:0]  run_length;
    } out_item_t;

endpackage

// ----- sv/lcpq_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// LC presence qualifier configuration registers
// Write-only register file for threshold, repeat limit, hold time and
// enabled channel count.
// ----------------------------------------------------------------------------
module lcpq_cfg_regs
    import lcpq_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [LCPQ_CFG_IDX_W-1:0]  cfg_index,
    input  logic [LCPQ_CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TRIGGER_LEVEL: begin
                    cfg_next.trigger_level = cfg_wr_data[LCPQ_TRIG_W-1:0];
                end
                REG_REPEAT_NEEDED: begin
                    cfg_next.repeat_needed = cfg_wr_data[LCPQ_REP_W-1:0];
                end
                REG_HOLD_TIME: begin
                    cfg_next.hold_time = cfg_wr_data[LCPQ_HOLD_W-1:0];
                end
                REG_CHANNELS_IN_USE: begin
                    cfg_next.channels_in_use = cfg_wr_data[LCPQ_USE_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_level   <= TRIGGER_LEVEL_RST;
            cfg_reg.repeat_needed   <= REPEAT_NEEDED_RST;
            cfg_reg.hold_time       <= HOLD_TIME_RST;
            cfg_reg.channels_in_use <= CHANNELS_IN_USE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/lcpq_update.sv -----
// ----------------------------------------------------------------------------
// LC presence qualifier channel update
// Per-channel hold and run counters with a combinational read-modify-write
// of the addressed channel, written back on commit.
// ----------------------------------------------------------------------------
module lcpq_update
    import lcpq_pkg::*;
#(
    parameter int CHANNELS = LCPQ_CHANNELS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      commit,
    input  in_item_t  item,
    output out_item_t result
);

    localparam int DEPTH = (CHANNELS < LCPQ_CH_SPAN) ? CHANNELS : LCPQ_CH_SPAN;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [LCPQ_CH_W:0] DEPTH_LIM = DEPTH[LCPQ_CH_W:0];

    logic [LCPQ_HOLD_W-1:0] hold_count_reg [DEPTH];
    logic [LCPQ_REP_W-1:0]  low_run_reg    [DEPTH];

    logic [IDX_W-1:0]       idx;
    logic                   enabled;
    logic [LCPQ_HOLD_W-1:0] hold_cur;
    logic [LCPQ_HOLD_W-1:0] hold_dec;
    logic [LCPQ_HOLD_W-1:0] hold_next;
    logic [LCPQ_REP_W-1:0]  run_cur;
    logic [LCPQ_REP_W-1:0]  run_inc;
    logic [LCPQ_REP_W-1:0]  run_next;

    assign idx     = item.channel[IDX_W-1:0];
    assign enabled = ({1'b0, item.channel} < {{(LCPQ_CH_W + 1 - LCPQ_USE_W){1'b0}},
                                              cfg.channels_in_use})
                     && ({1'b0, item.channel} < DEPTH_LIM);

    always_comb begin
        hold_cur  = hold_count_reg[idx];
        run_cur   = low_run_reg[idx];
        hold_dec  = (hold_cur != '0) ? hold_cur - 1'b1 : hold_cur;
        run_inc   = run_cur + 1'b1;
        hold_next = hold_dec;
        run_next  = run_cur;
        priority if (item.pulse_count >= {2'b00, cfg.trigger_level}) begin
            run_next = '0;
        end else if (run_cur < cfg.repeat_needed) begin
            run_next = run_inc;
            if (run_inc == cfg.repeat_needed) begin
                hold_next = cfg.hold_time;
            end
        end
    end

    always_comb begin
        if (enabled) begin
            result.accepted   = 1'b1;
            result.hold_value = hold_next;
            result.active     = (hold_next != '0);
            result.run_length = run_next;
        end else begin
            result = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                hold_count_reg[i] <= '0;
                low_run_reg[i]    <= '0;
            end
        end else if (commit && enabled) begin
            hold_count_reg[idx] <= hold_next;
            low_run_reg[idx]    <= run_next;
        end
    end

endmodule

// ----- sv/lc_presence_qualifier.sv -----
// ----------------------------------------------------------------------------
// LC presence qualifier
// Per-channel presence qualification of LC sensor oscillation counts.
// ----------------------------------------------------------------------------
// Takes one item per clock while s_ready is high and returns one result per
// item. The item is registered at acceptance; when the input stage advances,
// the addressed channel's counters are read, updated and written back while the
// result is loaded into the output register that drives m_valid. A result held
// by m_ready low stalls the input only once the input register is also full.
// Items on the same channel may follow each other directly.
// Channels at or above channels_in_use, or at or above CHANNELS, return a result
// with accepted low and all other fields zero. Configuration is written
// through cfg_wr_en/cfg_index/cfg_wr_data while no item is in flight.
module lc_presence_qualifier
    import lcpq_pkg::*;
#(
    parameter int CHANNELS = LCPQ_CHANNELS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [LCPQ_CFG_IDX_W-1:0]  cfg_index,
    input  logic [LCPQ_CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  in_item_t                   s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output out_item_t                  m_data
);

    cfg_t      cfg;
    out_item_t result;

    logic      in_valid_reg;
    logic      in_valid_next;
    in_item_t  in_item_reg;
    logic      m_valid_reg;
    logic      m_valid_next;
    out_item_t m_data_reg;
    logic      advance;
    logic      commit;

    lcpq_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    lcpq_update #(
        .CHANNELS (CHANNELS)
    ) u_update (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .commit  (commit),
        .item    (in_item_reg),
        .result  (result)
    );

    assign advance = !m_valid_reg || m_ready;
    assign commit  = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    assign in_valid_next = s_ready ? s_valid : in_valid_reg;
    assign m_valid_next  = advance ? in_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (commit) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled while output stage is empty");

    a_accept_loads_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted item not held in input stage");

    a_reject_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.accepted) |->
            (m_data.hold_value == '0 && m_data.run_length == '0 && !m_data.active))
        else $error("rejected item carries nonzero fields");

    a_active_matches_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.active == (m_data.hold_value != '0)))
        else $error("active flag disagrees with hold value");
`endif

endmodule
